// ----- sv/cfa_pkg.sv -----
// Package for the central force accumulator: payload structs, register
// indexes, law codes and controller/datapath command types. No dependencies.
package cfa_pkg;

  localparam int unsigned FracBitsDefault = 16;

  localparam logic [2:0] CfgForceLaw = 3'd0;
  localparam logic [2:0] CfgSelfX    = 3'd1;
  localparam logic [2:0] CfgSelfY    = 3'd2;
  localparam logic [2:0] CfgSelfRad  = 3'd3;
  localparam logic [2:0] CfgSelfWt   = 3'd4;
  localparam logic [2:0] CfgGravK    = 3'd5;
  localparam logic [2:0] CfgCoulK    = 3'd6;

  localparam logic [1:0] LawGravity = 2'd0;
  localparam logic [1:0] LawAnti    = 2'd1;
  localparam logic [1:0] LawElec    = 2'd2;
  localparam logic [1:0] LawNone    = 2'd3;

  typedef struct packed {
    logic signed [31:0] body_x;
    logic signed [31:0] body_y;
    logic [30:0]        body_radius;
    logic signed [31:0] body_weight;
    logic               last_body;
  } cfa_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               saturated;
  } cfa_out_t;

  typedef struct packed {
    logic load;    // capture item, compute d, S, contact limit
    logic prep;    // start sqrt
    logic r3;      // start products kq, kqQ, R^2, R^3, numerators
    logic divx;    // start x division
    logic divy;    // start y division
    logic accx;    // accumulate x term
    logic accy;    // accumulate y term
    logic emit;    // load output register, clear sums
  } cfa_cmd_t;

  typedef struct packed {
    logic contact_ok;
    logic sqrt_done;
    logic mul_done;
    logic div_done;
    logic last;
  } cfa_sts_t;

endpackage

// ----- sv/cfa_datapath.sv -----
// Datapath: offsets, iterative square root, serial multiplier, restoring
// divider and saturating accumulators. Depends on cfa_pkg.
module cfa_datapath import cfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfa_cmd_t    cmd_i,
  output cfa_sts_t    sts_o,
  input  cfa_in_t     item_i,
  input  logic [1:0]  law_i,
  input  logic [31:0] self_x_i,
  input  logic [31:0] self_y_i,
  input  logic [30:0] self_rad_i,
  input  logic [31:0] self_wt_i,
  input  logic [30:0] grav_k_i,
  input  logic [30:0] coul_k_i,
  output cfa_out_t    out_o
);

  localparam logic signed [47:0] AccMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] AccMin = 48'sh8000_0000_0000;

  logic [32:0]  adx_q, ady_q;
  logic [31:0]  rsum_q;
  logic [65:0]  sqx_q, sqy_q;
  logic [63:0]  lim_q;
  logic [67:0]  s_q;
  logic         law_ok_q, last_q, neg_q, sx_q, sy_q;
  logic [31:0]  bw_mag_q, sw_mag_q;
  logic [30:0]  k_q;

  logic signed [32:0] dx_w, dy_w;
  logic [32:0] adx_w, ady_w;
  logic [67:0] s_w;

  always_comb begin
    dx_w  = 33'(signed'(item_i.body_x)) - 33'(signed'(self_x_i));
    dy_w  = 33'(signed'(item_i.body_y)) - 33'(signed'(self_y_i));
    adx_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
    ady_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
    s_w   = 68'(sqx_q) + 68'(sqy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_ok_q <= 1'b0;
      last_q   <= 1'b0;
    end else if (cmd_i.load) begin
      law_ok_q <= (law_i != LawNone);
      last_q   <= item_i.last_body;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      adx_q    <= adx_w;
      ady_q    <= ady_w;
      rsum_q   <= 32'(self_rad_i) + 32'(item_i.body_radius);
      sx_q     <= dx_w[32];
      sy_q     <= dy_w[32];
      bw_mag_q <= item_i.body_weight[31] ? 32'(-item_i.body_weight) : item_i.body_weight;
      sw_mag_q <= self_wt_i[31] ? 32'(-self_wt_i) : self_wt_i;
      k_q      <= (law_i == LawElec) ? coul_k_i : grav_k_i;
      neg_q    <= (item_i.body_weight[31] != self_wt_i[31]) != (law_i != LawGravity);
    end
    sqx_q <= 66'(adx_q) * 66'(adx_q);
    sqy_q <= 66'(ady_q) * 66'(ady_q);
    lim_q <= 64'(rsum_q) * 64'(rsum_q);
    s_q   <= s_w;
  end

  // square root: one result bit per cycle
  logic [67:0] srem_q;
  logic [33:0] root_q;
  logic [5:0]  sbit_q;
  logic        sbusy_q;
  logic [35:0] trial_w;
  logic [67:0] pair_w;

  always_comb begin
    pair_w  = {srem_q[65:0], s_q[2*sbit_q +: 2]};
    trial_w = {root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      sbit_q  <= '0;
    end else if (cmd_i.prep) begin
      sbusy_q <= 1'b1;
      sbit_q  <= 6'd33;
    end else if (sbusy_q) begin
      if (sbit_q == 6'd0) sbusy_q <= 1'b0;
      else sbit_q <= sbit_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      srem_q <= '0;
      root_q <= '0;
    end else if (sbusy_q) begin
      if (pair_w >= 68'(trial_w)) begin
        srem_q <= pair_w - 68'(trial_w);
        root_q <= {root_q[32:0], 1'b1};
      end else begin
        srem_q <= pair_w;
        root_q <= {root_q[32:0], 1'b0};
      end
    end
  end

  // shift-add multiplier, 128-bit multiplicand by 1 multiplier bit per cycle
  // computes kq = k*|q|, kqQ = kq*|Q|, R2 = R*R, R3 = R2*R, then numerators
  logic [127:0] macc_q, mcand_q;
  logic [101:0] mplier_q;
  logic [6:0]   mcnt_q;
  logic         mbusy_q;
  logic [2:0]   mop_q;
  logic [127:0] kqq_q, r3_q, numx_q, numy_q;
  logic [63:0]  kq_q;
  logic [67:0]  r2_q;

  localparam logic [2:0] OpKq = 3'd0, OpKqq = 3'd1, OpR2 = 3'd2, OpR3 = 3'd3,
                         OpNx = 3'd4, OpNy = 3'd5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mop_q   <= OpKq;
      mcnt_q  <= '0;
    end else if (cmd_i.r3) begin
      mbusy_q <= 1'b1;
      mop_q   <= OpKq;
      mcnt_q  <= 7'd35;
    end else if (mbusy_q) begin
      if (mcnt_q == 7'd0) begin
        if (mop_q == OpNy) mbusy_q <= 1'b0;
        else begin
          mop_q  <= mop_q + 3'd1;
          mcnt_q <= 7'd35;
        end
      end else mcnt_q <= mcnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mbusy_q && mcnt_q == 7'd35) begin
      macc_q <= '0;
      case (mop_q)
        OpKq: begin mcand_q <= 128'(k_q);      mplier_q <= 102'(sw_mag_q); end
        OpKqq: begin mcand_q <= 128'(kq_q);    mplier_q <= 102'(bw_mag_q); end
        OpR2: begin mcand_q <= 128'(root_q);   mplier_q <= 102'(root_q);   end
        OpR3: begin mcand_q <= 128'(r2_q);     mplier_q <= 102'(root_q);   end
        OpNx: begin mcand_q <= kqq_q;          mplier_q <= 102'(adx_q);    end
        OpNy: begin mcand_q <= kqq_q;          mplier_q <= 102'(ady_q);    end
        default: begin mcand_q <= '0;          mplier_q <= '0;             end
      endcase
    end else if (mbusy_q) begin
      if (mcnt_q == 7'd0) begin
        case (mop_q)
          OpKq:  kq_q   <= macc_q[63:0];
          OpKqq: kqq_q  <= macc_q;
          OpR2:  r2_q   <= macc_q[67:0];
          OpR3:  r3_q   <= macc_q;
          OpNx:  numx_q <= macc_q;
          OpNy:  numy_q <= macc_q;
          default: ;
        endcase
      end else begin
        if (mplier_q[0]) macc_q <= macc_q + mcand_q;
        mcand_q  <= {mcand_q[126:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[101:1]};
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [127:0] drem_q, dnum_q, quo_q;
  logic [7:0]   dcnt_q;
  logic         dbusy_q;
  logic [128:0] dshift_w;

  assign dshift_w = {drem_q, dnum_q[127]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.divx || cmd_i.divy) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= 8'd128;
    end else if (dbusy_q) begin
      if (dcnt_q == 8'd1) dbusy_q <= 1'b0;
      dcnt_q <= dcnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.divx || cmd_i.divy) begin
      drem_q <= '0;
      quo_q  <= '0;
      dnum_q <= cmd_i.divx ? numx_q : numy_q;
    end else if (dbusy_q) begin
      dnum_q <= {dnum_q[126:0], 1'b0};
      if (dshift_w >= {1'b0, r3_q}) begin
        drem_q <= 128'(dshift_w - {1'b0, r3_q});
        quo_q  <= {quo_q[126:0], 1'b1};
      end else begin
        drem_q <= dshift_w[127:0];
        quo_q  <= {quo_q[126:0], 1'b0};
      end
    end
  end

  // term saturation and accumulation
  logic signed [47:0] sum_x_q, sum_y_q, term_w, add_base_w;
  logic signed [48:0] add_w;
  logic               tneg_w;

  always_comb begin
    tneg_w = neg_q != (cmd_i.accx ? sx_q : sy_q);
    if (quo_q > 128'(AccMax)) term_w = tneg_w ? AccMin : AccMax;
    else term_w = tneg_w ? 48'(-signed'(quo_q[47:0])) : signed'(quo_q[47:0]);
    add_base_w = cmd_i.accx ? sum_x_q : sum_y_q;
    add_w = 49'(add_base_w) + 49'(term_w);
  end

  function automatic logic signed [47:0] sat48(logic signed [48:0] v);
    if (v > 49'(AccMax)) return AccMax;
    if (v < 49'(AccMin)) return AccMin;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic clip_x_w, clip_y_w;
  assign clip_x_w = (sum_x_q > 48'sh0000_7FFF_FFFF) || (sum_x_q < -48'sh0000_8000_0000);
  assign clip_y_w = (sum_y_q > 48'sh0000_7FFF_FFFF) || (sum_y_q < -48'sh0000_8000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (cmd_i.accx) begin
      sum_x_q <= sat48(add_w);
    end else if (cmd_i.accy) begin
      sum_y_q <= sat48(add_w);
    end else if (cmd_i.emit) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_o.force_x   <= clip32(sum_x_q);
      out_o.force_y   <= clip32(sum_y_q);
      out_o.saturated <= clip_x_w || clip_y_w;
    end
  end

  assign sts_o.contact_ok = law_ok_q && (s_w > 68'(lim_q));
  assign sts_o.last       = last_q;
  assign sts_o.sqrt_done  = !sbusy_q;
  assign sts_o.mul_done   = !mbusy_q;
  assign sts_o.div_done   = !dbusy_q;

endmodule

// ----- sv/cfa_ctrl.sv -----
// Controller: sequences load, root, products, divides, accumulate and emit.
// Depends on cfa_pkg.
module cfa_ctrl import cfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  cfa_sts_t sts_i,
  output cfa_cmd_t cmd_o
);

  localparam logic [3:0] StIdle = 4'd0, StChk = 4'd1, StSqrt = 4'd2, StMul = 4'd3,
                         StDivX = 4'd4, StAccX = 4'd5, StDivY = 4'd6, StAccY = 4'd7,
                         StEmit = 4'd8, StSq = 4'd9;

  logic [3:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       sq_go_q, mul_go_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && out_stall_i;
    cmd_o   = '0;
    in_stall_o = (state_q != StIdle);
    case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = StSq;
      end
      StSq: state_d = StChk;
      StChk: begin
        if (sts_i.contact_ok) begin
          cmd_o.prep = 1'b1;
          state_d = StSqrt;
        end else state_d = sts_i.last ? StEmit : StIdle;
      end
      StSqrt: if (!sq_go_q && sts_i.sqrt_done) begin
        cmd_o.r3 = 1'b1;
        state_d = StMul;
      end
      StMul: if (!mul_go_q && sts_i.mul_done) begin
        cmd_o.divx = 1'b1;
        state_d = StDivX;
      end
      StDivX: if (sts_i.div_done) begin
        cmd_o.accx = 1'b1;
        state_d = StAccX;
      end
      StAccX: begin
        cmd_o.divy = 1'b1;
        state_d = StDivY;
      end
      StDivY: if (sts_i.div_done) begin
        cmd_o.accy = 1'b1;
        state_d = StAccY;
      end
      StAccY: state_d = sts_i.last ? StEmit : StIdle;
      StEmit: if (!ov_q || !out_stall_i) begin
        cmd_o.emit = 1'b1;
        ov_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ov_q     <= 1'b0;
      sq_go_q  <= 1'b0;
      mul_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ov_q     <= ov_d;
      sq_go_q  <= cmd_o.prep;
      mul_go_q <= cmd_o.r3;
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ----- sv/central_force_accumulator_core.sv -----
// Top level of the central force accumulator: config registers, controller
// and datapath. Depends on cfa_pkg, cfa_ctrl, cfa_datapath.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  cfa_in_t
//   out      output     out_valid/out_stall cfa_out_t
//   cfg      input      cfg_valid/cfg_ready index, data
//
// An item without contact passes load and contact check only; with contact it runs
// 34 root steps, six shift-add products of 34 steps, two 128-step divides.
// For the last item the controller then loads the output register, and waits
// first while an earlier result still waits under out_stall_i.
// Reset clears sums, config registers and control; no clearing pass.
// The output register holds a valid result while out_stall_i is high; new items still enter.
module central_force_accumulator_core import cfa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  cfa_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output cfa_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [30:0] KOne = 31'(1) << FRACTION_BITS;

  logic [1:0]  law_q;
  logic [31:0] self_x_q, self_y_q, self_wt_q;
  logic [30:0] self_rad_q, grav_k_q, coul_k_q;
  cfa_cmd_t    cmd_w;
  cfa_sts_t    sts_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_q      <= LawGravity;
      self_x_q   <= '0;
      self_y_q   <= '0;
      self_rad_q <= '0;
      self_wt_q  <= '0;
      grav_k_q   <= KOne;
      coul_k_q   <= KOne;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgForceLaw: law_q      <= cfg_data_i[1:0];
        CfgSelfX:    self_x_q   <= cfg_data_i;
        CfgSelfY:    self_y_q   <= cfg_data_i;
        CfgSelfRad:  self_rad_q <= cfg_data_i[30:0];
        CfgSelfWt:   self_wt_q  <= cfg_data_i;
        CfgGravK:    grav_k_q   <= cfg_data_i[30:0];
        CfgCoulK:    coul_k_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  cfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts_w), .cmd_o(cmd_w)
  );

  cfa_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd_w), .sts_o(sts_w), .item_i(in_data_i),
    .law_i(law_q), .self_x_i(self_x_q), .self_y_i(self_y_q),
    .self_rad_i(self_rad_q), .self_wt_i(self_wt_q), .grav_k_i(grav_k_q),
    .coul_k_i(coul_k_q), .out_o(out_data_o)
  );

endmodule

// ----- sv/cfa_checker.sv -----
// Port checker for central_force_accumulator_core, bound to the top level.
// Depends on cfa_pkg.
module cfa_checker import cfa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input cfa_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed under stall");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted twice in a row");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      (out_data_o.force_x == 32'sh7FFF_FFFF) || (out_data_o.force_x == 32'sh8000_0000) ||
      (out_data_o.force_y == 32'sh7FFF_FFFF) || (out_data_o.force_y == 32'sh8000_0000))
    else $error("saturation flag inconsistent");

endmodule

bind central_force_accumulator_core cfa_checker u_cfa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
